// ===== design/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg: shared types and constants for the motor bump profile PWM block
// Holds the transaction payloads, command and mode codes, the sequencer state
// types and the fixed-point constants of the bump profile arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbp_pkg;

  // Field widths.
  localparam int TimeW  = 32;
  localparam int DurW   = 16;
  localparam int StepW  = 8;
  localparam int DutyW  = 8;
  localparam int LevelW = 9;
  localparam int DataW  = 32;
  localparam int PaddrW = 3;
  localparam int RegSel = 2;

  // Iteration counter covers one bit of the quotient or multiplier per cycle.
  localparam int CntW = $clog2(DurW);

  // Square of the folded fraction and the shared adder width.
  localparam int SqW        = 2 * DurW;
  localparam int AluW       = 53;
  localparam int ScaleShift = 8;
  localparam int DutyLsb    = 44;

  localparam logic [DurW-1:0]  HalfFrac   = 16'd32768;
  localparam logic [DurW-1:0]  WeightBase = 16'd49152;
  localparam logic [DurW-1:0]  DurReset   = 16'd2000;
  localparam logic [StepW-1:0] StepReset  = 8'd5;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_START_UP   = 3'd1,
    CMD_START_DOWN = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_SWAP       = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic {
    REG_DURATION = 1'b0,
    REG_STEP     = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BUMP,
    ST_LOAD
  } ctrl_state_t;

  typedef enum logic [2:0] {
    BP_IDLE,
    BP_DIV,
    BP_PREP,
    BP_SQ,
    BP_MUL,
    BP_SCALE
  } bump_phase_t;

  typedef struct packed {
    command_t         command;
    logic [TimeW-1:0] now_ms;
  } cmd_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             direction_level;
    mode_t            motion_state;
  } res_item_t;

  typedef struct packed {
    logic            start;
    logic [DurW-1:0] elapsed;
    logic [DurW-1:0] duration;
  } bump_req_t;

  typedef struct packed {
    logic             done;
    logic [DutyW-1:0] duty;
  } bump_rsp_t;

endpackage

// ===== design/mbp_bump_unit.sv =====
// ----------------------------------------------------------------------------
// mbp_bump_unit: iterative bump profile duty calculator
// Divides the elapsed time by the duration, folds the fraction about its
// midpoint and forms the cubic bump, all through one shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbp_bump_unit
  import mbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bump_req_t req,
  output bump_rsp_t rsp
);

  bump_phase_t phase;
  bump_phase_t phase_next;

  logic [DurW-1:0]  divisor;
  logic [DurW-1:0]  rem;
  logic [DurW-1:0]  quo;
  logic [DurW-1:0]  u;
  logic [DurW-1:0]  wp;
  logic [DurW-1:0]  mreg;
  logic [SqW-1:0]   sq;
  logic [AluW-1:0]  acc;
  logic [CntW-1:0]  cnt;
  logic [DutyW-1:0] duty;
  logic             done;

  logic [AluW-1:0]  alu_a;
  logic [AluW-1:0]  alu_b;
  logic             alu_sub;
  logic [AluW:0]    alu_sum;
  logic             no_borrow;
  logic [DurW-1:0]  u_fold;
  logic             last_step;

  // The one adder that every working phase shares; the top bit is the carry, which
  // on a subtraction means no borrow.
  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (AluW + 1)'(alu_sub);
  assign no_borrow = alu_sum[AluW];
  assign last_step = (cnt == CntW'(DurW - 1));
  assign u_fold    = (quo <= HalfFrac) ? quo : (~quo + 16'd1);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (phase)
      BP_DIV: begin
        alu_a   = AluW'({rem, 1'b0});
        alu_b   = AluW'(divisor);
        alu_sub = 1'b1;
      end
      BP_PREP: begin
        alu_a   = AluW'(WeightBase);
        alu_b   = AluW'(u_fold);
        alu_sub = 1'b1;
      end
      BP_SQ: begin
        alu_a = {acc[AluW-2:0], 1'b0};
        alu_b = mreg[DurW-1] ? AluW'(u) : '0;
      end
      BP_MUL: begin
        alu_a = {acc[AluW-2:0], 1'b0};
        alu_b = mreg[DurW-1] ? AluW'(sq) : '0;
      end
      BP_SCALE: begin
        alu_a   = {acc[AluW-ScaleShift-1:0], {ScaleShift{1'b0}}};
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      BP_IDLE:  if (req.start) phase_next = BP_DIV;
      BP_DIV:   if (last_step) phase_next = BP_PREP;
      BP_PREP:  phase_next = BP_SQ;
      BP_SQ:    if (last_step) phase_next = BP_MUL;
      BP_MUL:   if (last_step) phase_next = BP_SCALE;
      BP_SCALE: phase_next = BP_IDLE;
      default:  phase_next = BP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= BP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == BP_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      BP_IDLE: begin
        if (req.start) begin
          rem     <= req.elapsed;
          divisor <= req.duration;
          quo     <= '0;
          cnt     <= '0;
        end
      end
      BP_DIV: begin
        rem <= no_borrow ? alu_sum[DurW-1:0] : {rem[DurW-2:0], 1'b0};
        quo <= {quo[DurW-2:0], no_borrow};
        cnt <= cnt + 1'b1;
      end
      BP_PREP: begin
        u    <= u_fold;
        wp   <= alu_sum[DurW-1:0];
        mreg <= u_fold;
        acc  <= '0;
        cnt  <= '0;
      end
      BP_SQ: begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          sq   <= alu_sum[SqW-1:0];
          acc  <= '0;
          mreg <= wp;
        end else begin
          acc  <= alu_sum[AluW-1:0];
          mreg <= {mreg[DurW-2:0], 1'b0};
        end
      end
      BP_MUL: begin
        acc  <= alu_sum[AluW-1:0];
        mreg <= {mreg[DurW-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
      end
      BP_SCALE: begin
        duty <= alu_sum[DutyLsb +: DutyW];
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.duty = duty;

endmodule

// ===== design/motor_bump_profile_pwm.sv =====
// ----------------------------------------------------------------------------
// motor_bump_profile_pwm: bump motion profile PWM generator
// A moving tick within the profile runs through the divide, fold and two
// multiplies of the bump unit before its result is offered; every other command
// goes from evaluation straight to the load state. One command transaction is
// worked on at a time; the next is taken only once the sequencer is idle again.
// Reset (synchronous, active high) stops the motor, clears duty, direction and
// start time, and restores a 2000 ms duration and a ramp step of 5.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_bump_profile_pwm
  import mbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_item_t         cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output res_item_t         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  // Configuration registers.
  logic [DurW-1:0]  move_duration_ms;
  logic [StepW-1:0] stop_ramp_step;

  // Sequencer and the command held while it is worked on.
  ctrl_state_t state;
  ctrl_state_t state_next;
  cmd_item_t   item;

  // Motor state.
  mode_t              mode;
  logic [TimeW-1:0]   start_stamp;
  logic signed [LevelW-1:0] duty_level;
  logic               dir_level;

  logic [TimeW-1:0] elapsed;
  logic             in_profile;
  logic             moving;
  logic             bump_go;
  logic             bump_start;
  logic             res_load;
  logic             cfg_write;
  reg_index_t       cfg_index;
  logic [DutyW-1:0] duty_shown;

  bump_req_t bump_req;
  bump_rsp_t bump_rsp;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high, so there are no wait states. Only the register select bit of the
  // byte address is decoded.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[RegSel]);

  always_ff @(posedge clk) begin
    if (rst) begin
      move_duration_ms <= DurReset;
      stop_ramp_step   <= StepReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DURATION: move_duration_ms <= pwdata[DurW-1:0];
        REG_STEP:     stop_ramp_step   <= pwdata[StepW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_DURATION: prdata = DataW'(move_duration_ms);
      REG_STEP:     prdata = DataW'(stop_ramp_step);
    endcase
  end

  // --------------------------------------------------------------------------
  // Command evaluation. The elapsed time is taken modulo 2^32, so the
  // millisecond counter may wrap during a movement. Once it reaches the
  // duration the movement ends with zero duty; a zero duration therefore ends
  // the movement at the first tick.
  // --------------------------------------------------------------------------
  assign elapsed    = item.now_ms - start_stamp;
  assign in_profile = elapsed < TimeW'(move_duration_ms);
  assign moving     = (mode == MODE_UP) || (mode == MODE_DOWN);
  assign bump_go    = (item.command == CMD_TICK) && moving && in_profile;

  // Within the profile the elapsed time is below a 16-bit duration, so its
  // low half carries all of it.
  assign bump_req.start    = bump_start;
  assign bump_req.elapsed  = elapsed[DurW-1:0];
  assign bump_req.duration = move_duration_ms;

  mbp_bump_unit u_bump (
    .clk (clk),
    .rst (rst),
    .req (bump_req),
    .rsp (bump_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer. A command transaction is taken only in idle. The result is
  // parked in the output register, so a new command may be accepted while
  // the previous result is still stalled; the sequencer then waits in the
  // load state until the output register is free.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    bump_start = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (bump_go) begin
          bump_start = 1'b1;
          state_next = ST_BUMP;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_BUMP: begin
        if (bump_rsp.done) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      item <= cmd;
    end
  end

  // --------------------------------------------------------------------------
  // Motor state update. Start commands are ignored when the block is already
  // moving that way. Swap exchanges up and down but leaves the direction pin
  // and the start time alone, and does nothing while stopped. A stopped tick
  // ramps a positive duty down by the step, which may overshoot to as low as
  // -254, and walks a negative duty back up by one.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_STOP;
      start_stamp <= '0;
      duty_level  <= '0;
      dir_level   <= 1'b0;
    end else begin
      if (state == ST_EVAL) begin
        case (item.command)
          CMD_TICK: begin
            if (moving) begin
              if (!in_profile) begin
                duty_level <= '0;
                mode       <= MODE_STOP;
              end
            end else if (duty_level > 9'sd0) begin
              duty_level <= duty_level - $signed({1'b0, stop_ramp_step});
            end else if (duty_level < 9'sd0) begin
              duty_level <= duty_level + 9'sd1;
            end
          end
          CMD_START_UP: begin
            if (mode != MODE_UP) begin
              dir_level   <= 1'b0;
              mode        <= MODE_UP;
              start_stamp <= item.now_ms;
            end
          end
          CMD_START_DOWN: begin
            if (mode != MODE_DOWN) begin
              dir_level   <= 1'b1;
              mode        <= MODE_DOWN;
              start_stamp <= item.now_ms;
            end
          end
          CMD_STOP: begin
            mode <= MODE_STOP;
          end
          CMD_SWAP: begin
            if (mode == MODE_UP) begin
              mode <= MODE_DOWN;
            end else if (mode == MODE_DOWN) begin
              mode <= MODE_UP;
            end
          end
          default: begin
          end
        endcase
      end
      if (state == ST_BUMP && bump_rsp.done) begin
        duty_level <= $signed({1'b0, bump_rsp.duty});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A negative internal duty is shown as zero.
  // --------------------------------------------------------------------------
  assign duty_shown = (duty_level > 9'sd0) ? duty_level[DutyW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.duty            <= duty_shown;
      res.direction_level <= dir_level;
      res.motion_state    <= mode;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_done_in_bump : assert property (@(posedge clk) disable iff (rst)
    bump_rsp.done |-> state == ST_BUMP)
    else $error("bump unit finished outside the bump wait state");

  a_accept_to_eval : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> state == ST_EVAL)
    else $error("accepted command was not evaluated next cycle");

  a_duty_floor : assert property (@(posedge clk) disable iff (rst)
    duty_level >= -9'sd254)
    else $error("internal duty ramped below its floor");

  a_overrun_stops : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && item.command == CMD_TICK && moving && !in_profile)
    |=> (mode == MODE_STOP && duty_level == 9'sd0))
    else $error("movement past its duration did not stop with zero duty");

endmodule

// ===== sim/motor_bump_profile_pwm_tb.sv =====
// ----------------------------------------------------------------------------
// motor_bump_profile_pwm_tb: self-checking bench for the bump profile PWM block
// Drives command transactions through the valid/stall port and reprograms the
// duration and ramp step between phases over the APB-style port. A
// transaction-level tracker predicts every result transaction, and each result is
// compared field by field as it is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_bump_profile_pwm_tb;
  import mbp_pkg::*;

  // Command codes that the block does not decode; they must leave all state alone.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Cycle count at which the guard declares the block hung.
  localparam int CYCLE_LIMIT = 500_000;

  // Percentage of cycles on which either side holds back.
  localparam int IDLE_PERCENT = 27;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  cmd_item_t         cmd = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  res_item_t         res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int cycles = 0;

  // While set, neither side idles, so back-to-back transactions are exercised.
  bit calm = 1'b0;

  motor_bump_profile_pwm u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd     (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Tracks the motor state as the block should see it, and holds the outputs
  // that are still owed, oldest first.
  class motor_profile_tracker;
    mode_t              mode;
    logic [TimeW-1:0]   start_ms;
    logic signed [8:0]  duty_level;
    logic               dir_level;
    logic [DurW-1:0]    duration;
    logic [StepW-1:0]   ramp_step;
    res_item_t          owed_outputs[$];
    int                 mismatches;

    function new();
      mode       = MODE_STOP;
      start_ms   = '0;
      duty_level = '0;
      dir_level  = 1'b0;
      duration   = DurReset;
      ramp_step  = StepReset;
      mismatches = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [DataW-1:0] value);
      case (idx)
        REG_DURATION: duration = value[DurW-1:0];
        REG_STEP:     ramp_step = value[StepW-1:0];
        default: ;
      endcase
    endfunction

    // Height of the bump at a point strictly inside the movement. The fraction
    // is folded about the midpoint, then scaled by the cubic 3x^2 - 2x^3 of x = 2u in
    // fixed point, with u the folded fraction, so the midpoint gives exactly 255.
    function logic [DutyW-1:0] bump_height(logic [DurW-1:0] elapsed, logic [DurW-1:0] dur);
      logic [63:0] frac;
      logic [63:0] u;
      logic [63:0] v;
      frac = ({48'd0, elapsed} << 16) / {48'd0, dur};
      u = (frac <= 64'd32768) ? frac : (64'd65536 - frac);
      v = 64'd1020 * u * u * (64'd196608 - 64'd4 * u);
      return v[55:48];
    endfunction

    function void apply_command(cmd_item_t item);
      res_item_t        out;
      logic [TimeW-1:0] elapsed;
      case (item.command)
        CMD_TICK: begin
          if (mode != MODE_STOP) begin
            // Elapsed time is taken modulo 2^32, so a wrapped clock is fine.
            elapsed = item.now_ms - start_ms;
            if (elapsed < {16'd0, duration}) begin
              duty_level = $signed({1'b0, bump_height(elapsed[DurW-1:0], duration)});
            end else begin
              duty_level = '0;
              mode = MODE_STOP;
            end
          end else if (duty_level > 0) begin
            duty_level = 9'(int'(duty_level) - int'(ramp_step));
          end else if (duty_level < 0) begin
            duty_level = duty_level + 9'sd1;
          end
        end
        CMD_START_UP: begin
          if (mode != MODE_UP) begin
            dir_level = 1'b0;
            mode = MODE_UP;
            start_ms = item.now_ms;
          end
        end
        CMD_START_DOWN: begin
          if (mode != MODE_DOWN) begin
            dir_level = 1'b1;
            mode = MODE_DOWN;
            start_ms = item.now_ms;
          end
        end
        CMD_STOP: mode = MODE_STOP;
        CMD_SWAP: begin
          // Only the state flips; the direction pin and start time stay put.
          if (mode == MODE_UP) begin
            mode = MODE_DOWN;
          end else if (mode == MODE_DOWN) begin
            mode = MODE_UP;
          end
        end
        default: ;
      endcase
      out.duty = (duty_level > 0) ? duty_level[DutyW-1:0] : '0;
      out.direction_level = dir_level;
      out.motion_state = mode;
      owed_outputs.push_back(out);
    endfunction

    function void compare_output(res_item_t got);
      res_item_t want;
      if (owed_outputs.size() == 0) begin
        $error("result transaction with nothing outstanding: duty %0d dir %0d state %0d",
               got.duty, got.direction_level, got.motion_state);
        mismatches++;
        return;
      end
      want = owed_outputs.pop_front();
      if (got.duty !== want.duty) begin
        $error("duty: expected %0d, actual %0d", want.duty, got.duty);
        mismatches++;
      end
      if (got.direction_level !== want.direction_level) begin
        $error("direction_level: expected %0d, actual %0d",
               want.direction_level, got.direction_level);
        mismatches++;
      end
      if (got.motion_state !== want.motion_state) begin
        $error("motion_state: expected %0d, actual %0d", want.motion_state, got.motion_state);
        mismatches++;
      end
    endfunction
  endclass

  motor_profile_tracker tracker = new();

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Global guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  // Result side: every accepted result transaction is checked at the edge that
  // accepts it, and the stall for the next cycle is chosen at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        tracker.compare_output(res);
      end
      res_stall <= take_break();
    end
  end

  // Offers one command transaction and returns at the edge that accepts it.
  // Valid is left high so that a following transaction can go out back to back.
  task automatic issue(command_t code, logic [TimeW-1:0] stamp);
    cmd_item_t item;
    item.command = code;
    item.now_ms = stamp;
    while (take_break()) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (cmd_stall);
    tracker.apply_command(item);
  endtask

  // Brings the block to rest: no command offered and every result delivered.
  // Every command yields a result, so once the last one is in the block is idle;
  // the closing wait only gives the result handshake time to retire.
  task automatic settle();
    cmd_valid <= 1'b0;
    while (tracker.owed_outputs.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: a setup phase, then an access phase held until pready.
  task automatic write_reg(reg_index_t idx, logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One random phase at a fixed setting. Most traffic is ticks walking the
  // clock forward through a movement, with starts, stops and swaps mixed in;
  // a few transactions carry undecoded codes or a clock value from nowhere.
  task automatic run_random_phase(logic [DurW-1:0] dur, logic [StepW-1:0] step, int count,
                                  bit quiet);
    int               roll;
    logic [TimeW-1:0] clock_ms;
    settle();
    write_reg(REG_DURATION, DataW'(dur));
    write_reg(REG_STEP, DataW'(step));
    calm = quiet;
    clock_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      // Steps of up to a sixth of the duration give several ticks per movement
      // and let the clock run past the end of the profile now and then.
      clock_ms = clock_ms + $urandom_range(0, int'(dur) / 6 + 2);
      if (roll < 55) begin
        issue(CMD_TICK, clock_ms);
      end else if (roll < 67) begin
        issue(CMD_START_UP, clock_ms);
      end else if (roll < 79) begin
        issue(CMD_START_DOWN, clock_ms);
      end else if (roll < 87) begin
        issue(CMD_STOP, clock_ms);
      end else if (roll < 94) begin
        issue(CMD_SWAP, clock_ms);
      end else if (roll < 97) begin
        issue(command_t'(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))), $urandom);
      end else begin
        clock_ms = $urandom;
        issue(CMD_TICK, clock_ms);
      end
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    logic [TimeW-1:0] t0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: 2000 ms profile, ramp step of 5. The movement starts just
    // before the clock wraps, so every tick measures across the wrap.
    t0 = 32'hFFFF_FE00;
    issue(command_t'(CMD_SPARE_LO), 32'hFFFF_FFFF);
    issue(command_t'(CMD_SPARE_HI), 32'h0000_0000);
    issue(CMD_SWAP, 32'd0);                    // swap while stopped stays stopped
    issue(CMD_START_UP, t0);
    issue(CMD_START_UP, t0 + 32'd100);         // already moving up: ignored
    issue(CMD_TICK, t0 + 32'd1000);            // midpoint of the bump, full duty
    issue(CMD_SWAP, t0 + 32'd1100);            // state flips, pin and start stay
    issue(CMD_TICK, t0 + 32'd1999);            // last millisecond of the profile
    issue(CMD_TICK, t0 + 32'd2000);            // profile over: duty 0, stopped
    issue(CMD_START_DOWN, 32'd5000);
    issue(CMD_TICK, 32'd6000);
    issue(CMD_STOP, 32'd6001);                 // stop keeps the duty it had
    issue(CMD_TICK, 32'd6002);                 // and the stop tick ramps it down

    // Largest ramp step drives the duty negative, then it climbs back by one.
    settle();
    write_reg(REG_STEP, DataW'(8'd255));
    issue(CMD_START_UP, 32'd0);
    issue(CMD_TICK, 32'd500);
    issue(CMD_STOP, 32'd501);
    issue(CMD_TICK, 32'd502);
    issue(CMD_TICK, 32'd503);

    // A zero ramp step holds a positive duty while stopped.
    settle();
    write_reg(REG_STEP, DataW'(8'd0));
    issue(CMD_START_UP, 32'd0);
    issue(CMD_TICK, 32'd500);
    issue(CMD_STOP, 32'd501);
    issue(CMD_TICK, 32'd502);

    // Zero duration: the first moving tick ends the movement.
    settle();
    write_reg(REG_DURATION, DataW'(16'd0));
    issue(CMD_START_DOWN, 32'd7);
    issue(CMD_TICK, 32'd7);

    // One-millisecond profile: the only tick inside it sits at the very start.
    settle();
    write_reg(REG_DURATION, DataW'(16'd1));
    issue(CMD_START_UP, 32'd9);
    issue(CMD_TICK, 32'd9);
    issue(CMD_TICK, 32'd10);

    // Random phases, the extremes of the duration and the largest ramp step among
    // them. The fourth phase runs without any idling on either side.
    run_random_phase(DurReset, StepReset, 160, 1'b0);
    run_random_phase(16'd65535, 8'd255, 160, 1'b0);
    run_random_phase(16'd1, 8'd1, 150, 1'b0);
    run_random_phase(DurW'($urandom_range(20, 400)), StepW'($urandom_range(1, 255)), 160, 1'b1);
    run_random_phase(16'd0, StepW'($urandom_range(1, 255)), 150, 1'b0);
    run_random_phase(DurW'($urandom_range(2, 60)), StepW'($urandom_range(1, 20)), 170, 1'b0);

    // Drain, then leave room for any stray result transaction to show up.
    settle();
    repeat (60) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.owed_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mbp_pkg.sv
design/mbp_bump_unit.sv
design/motor_bump_profile_pwm.sv
sim/motor_bump_profile_pwm_tb.sv
